// ===== rtl/round_robin_dispatch_reorder_unit_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef ROUND_ROBIN_DISPATCH_REORDER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_DISPATCH_REORDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RRDR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrdr assertion failed");
`define RRDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrdr assertion failed");
`define RRDR_ASSERT_DELAY2(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("rrdr assertion failed");
`else
`define RRDR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define RRDR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define RRDR_ASSERT_DELAY2(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/rrdr_pkg.sv =====
package rrdr_pkg;

   localparam int TAG_BITS     = 16;
   localparam int HANDLE_BITS  = 32;
   localparam int TIME_BITS    = 64;
   localparam int MAX_WORKERS  = 8;
   localparam int WC_BITS      = 4;
   localparam int WIDX_BITS    = 3;
   localparam int MIF_BITS     = 5;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 5;
   localparam int CNT_OUT_BITS = 5;

   typedef enum logic [1:0] {
      CMD_ENQUEUE  = 2'd0,
      CMD_COMPLETE = 2'd1,
      CMD_POP      = 2'd2,
      CMD_RESTART  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_NOT_READY  = 3'd2,
      ST_BAD        = 3'd3,
      ST_NO_WORKERS = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WORKER_COUNT  = 1'd0,
      CSR_MAX_IN_FLIGHT = 1'd1
   } csr_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       do_enq;
      logic       do_cpl;
      logic       do_pop;
      logic       do_clear;
      logic       echo_tag;
      logic       rsp_en;
      status_type status;
   } dp_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    no_workers;
      logic    full;
      logic    cpl_bad;
      logic    pop_empty;
   } dp_stat_type;

endpackage

// ===== rtl/rrdr_ctrl.sv =====
module rrdr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  rrdr_pkg::dp_stat_type stat,
   output rrdr_pkg::dp_ctrl_type ctrl
);
   import rrdr_pkg::*;

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      ctrl          = '0;
      ctrl.status   = ST_OK;
      state_in      = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = EXEC;
            end
         end
         EXEC: begin
            ctrl.rsp_en = 1'b1;
            state_in    = IDLE;
            unique case (stat.cmd)
               CMD_ENQUEUE: begin
                  priority if (stat.no_workers) begin
                     ctrl.status = ST_NO_WORKERS;
                  end else if (stat.full) begin
                     ctrl.status = ST_FULL;
                  end else begin
                     ctrl.do_enq = 1'b1;
                  end
               end
               CMD_COMPLETE: begin
                  ctrl.echo_tag = 1'b1;
                  if (stat.cpl_bad) begin
                     ctrl.status = ST_BAD;
                  end else begin
                     ctrl.do_cpl = 1'b1;
                  end
               end
               CMD_POP: begin
                  if (stat.pop_empty) begin
                     ctrl.status = ST_NOT_READY;
                  end else begin
                     ctrl.do_pop = 1'b1;
                  end
               end
               CMD_RESTART: begin
                  ctrl.do_clear = 1'b1;
               end
               default: begin
                  ctrl.do_clear = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= ctrl.rsp_en;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/rrdr_dp.sv =====
module rrdr_dp #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrdr_pkg::dp_ctrl_type                ctrl,
   output rrdr_pkg::dp_stat_type                stat,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [rrdr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rrdr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [1:0]                           req_cmd,
   input  logic [rrdr_pkg::HANDLE_BITS-1:0]     req_frame_ref,
   input  logic [rrdr_pkg::TIME_BITS-1:0]       req_start_time,
   input  logic [rrdr_pkg::TAG_BITS-1:0]        req_done_seq,
   input  logic [rrdr_pkg::HANDLE_BITS-1:0]     req_result_ref,
   output logic [2:0]                           rsp_status,
   output logic [rrdr_pkg::WIDX_BITS-1:0]       rsp_worker_index,
   output logic [rrdr_pkg::TAG_BITS-1:0]        rsp_seq_out,
   output logic [rrdr_pkg::HANDLE_BITS-1:0]     rsp_frame_ref_out,
   output logic [rrdr_pkg::TIME_BITS-1:0]       rsp_start_time_out,
   output logic [rrdr_pkg::HANDLE_BITS-1:0]     rsp_result_ref_out,
   output logic [rrdr_pkg::CNT_OUT_BITS-1:0]    rsp_in_flight_count
);
   import rrdr_pkg::*;

   localparam int SLOT_BITS = $clog2(STORE_DEPTH);
   localparam int CNT_BITS  = $clog2(STORE_DEPTH + 1);
   localparam int CW        = (CNT_BITS > MIF_BITS) ? CNT_BITS : MIF_BITS;

   // configuration
   logic [WC_BITS-1:0]  worker_count_ff;
   logic [MIF_BITS-1:0] max_in_flight_ff;

   // control state
   logic [TAG_BITS-1:0]    next_tag_ff, next_tag_in;
   logic [TAG_BITS-1:0]    expected_ff, expected_in;
   logic [CNT_BITS-1:0]    outstanding_ff, outstanding_in;
   logic [WIDX_BITS-1:0]   rot_ff, rot_in;
   logic [STORE_DEPTH-1:0] filled_ff, filled_in;

   // captured transaction
   cmd_type                req_cmd_ff;
   logic [HANDLE_BITS-1:0] req_frame_ref_ff;
   logic [TIME_BITS-1:0]   req_start_time_ff;
   logic [TAG_BITS-1:0]    req_done_seq_ff;
   logic [HANDLE_BITS-1:0] req_result_ref_ff;

   // reorder store
   logic [HANDLE_BITS-1:0] slot_mem [STORE_DEPTH];
   logic [HANDLE_BITS-1:0] rd_data_ff;

   // response registers
   status_type             rsp_status_ff;
   logic [WIDX_BITS-1:0]   rsp_widx_ff;
   logic [TAG_BITS-1:0]    rsp_seq_ff;
   logic [HANDLE_BITS-1:0] rsp_fref_ff;
   logic [TIME_BITS-1:0]   rsp_time_ff;
   logic [HANDLE_BITS-1:0] rsp_rref_ff;
   logic [CNT_OUT_BITS-1:0] rsp_cnt_ff;

   logic [WC_BITS-1:0]   wc_eff;
   logic [CW-1:0]        credit;
   logic [CW-1:0]        mif_ext;
   logic [TAG_BITS-1:0]  window;
   logic [TAG_BITS-1:0]  cpl_off;
   logic [SLOT_BITS-1:0] cpl_slot;
   logic [SLOT_BITS-1:0] exp_slot;
   logic [SLOT_BITS-1:0] enq_slot;
   logic [WIDX_BITS-1:0] target;
   logic [WC_BITS-1:0]   target_inc;

   always_comb begin
      wc_eff = (worker_count_ff > WC_BITS'(MAX_WORKERS)) ? WC_BITS'(MAX_WORKERS)
                                                          : worker_count_ff;
      mif_ext = CW'(max_in_flight_ff);
      credit  = (max_in_flight_ff == '0 || mif_ext > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH)
                                                                     : mif_ext;
      window   = next_tag_ff - expected_ff;
      cpl_off  = req_done_seq_ff - expected_ff;
      // slot = tag mod depth; depth is a power of two
      cpl_slot = req_done_seq_ff[SLOT_BITS-1:0];
      exp_slot = expected_ff[SLOT_BITS-1:0];
      enq_slot = next_tag_ff[SLOT_BITS-1:0];
      // stale pointer after worker_count was lowered falls back to worker 0
      target     = ({1'b0, rot_ff} >= wc_eff) ? '0 : rot_ff;
      target_inc = {1'b0, target} + WC_BITS'(1);

      stat.cmd        = req_cmd_ff;
      stat.no_workers = (wc_eff == '0);
      stat.full       = (CW'(outstanding_ff) >= credit) ||
                        (window >= TAG_BITS'(STORE_DEPTH));
      stat.cpl_bad    = (cpl_off >= window) || filled_ff[cpl_slot] ||
                        (outstanding_ff == '0);
      stat.pop_empty  = (window == '0) || !filled_ff[exp_slot];
   end

   always_comb begin
      next_tag_in    = next_tag_ff;
      expected_in    = expected_ff;
      outstanding_in = outstanding_ff;
      rot_in         = rot_ff;
      filled_in      = filled_ff;
      priority if (ctrl.do_clear) begin
         next_tag_in    = '0;
         expected_in    = '0;
         outstanding_in = '0;
         rot_in         = '0;
         filled_in      = '0;
      end else if (ctrl.do_enq) begin
         filled_in[enq_slot] = 1'b0;
         next_tag_in    = next_tag_ff + TAG_BITS'(1);
         rot_in         = (target_inc >= wc_eff) ? '0 : target_inc[WIDX_BITS-1:0];
         outstanding_in = outstanding_ff + CNT_BITS'(1);
      end else if (ctrl.do_cpl) begin
         filled_in[cpl_slot] = 1'b1;
         outstanding_in = outstanding_ff - CNT_BITS'(1);
      end else if (ctrl.do_pop) begin
         filled_in[exp_slot] = 1'b0;
         expected_in = expected_ff + TAG_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff  <= WC_BITS'(1);
         max_in_flight_ff <= MIF_BITS'(2);
         next_tag_ff      <= '0;
         expected_ff      <= '0;
         outstanding_ff   <= '0;
         rot_ff           <= '0;
         filled_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_idx_type'(csr_index))
               CSR_WORKER_COUNT:  worker_count_ff  <= csr_wdata[WC_BITS-1:0];
               CSR_MAX_IN_FLIGHT: max_in_flight_ff <= csr_wdata[MIF_BITS-1:0];
               default:           worker_count_ff  <= worker_count_ff;
            endcase
         end
         next_tag_ff    <= next_tag_in;
         expected_ff    <= expected_in;
         outstanding_ff <= outstanding_in;
         rot_ff         <= rot_in;
         filled_ff      <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_cmd_ff        <= cmd_type'(req_cmd);
         req_frame_ref_ff  <= req_frame_ref;
         req_start_time_ff <= req_start_time;
         req_done_seq_ff   <= req_done_seq;
         req_result_ref_ff <= req_result_ref;
      end
   end

   // read port follows expected_tag; it is settled before the next EXEC
   always_ff @(posedge clock) begin
      if (ctrl.do_cpl) begin
         slot_mem[cpl_slot] <= req_result_ref_ff;
      end
      rd_data_ff <= slot_mem[exp_slot];
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_en) begin
         rsp_status_ff <= ctrl.status;
         rsp_widx_ff   <= ctrl.do_enq ? target : '0;
         priority if (ctrl.do_enq) begin
            rsp_seq_ff <= next_tag_ff;
         end else if (ctrl.echo_tag) begin
            rsp_seq_ff <= req_done_seq_ff;
         end else if (ctrl.do_pop) begin
            rsp_seq_ff <= expected_ff;
         end else begin
            rsp_seq_ff <= '0;
         end
         rsp_fref_ff <= ctrl.do_enq ? req_frame_ref_ff : '0;
         rsp_time_ff <= ctrl.do_enq ? req_start_time_ff : '0;
         rsp_rref_ff <= ctrl.do_pop ? rd_data_ff : '0;
         rsp_cnt_ff  <= CNT_OUT_BITS'(outstanding_in);
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_worker_index    = rsp_widx_ff;
   assign rsp_seq_out         = rsp_seq_ff;
   assign rsp_frame_ref_out   = rsp_fref_ff;
   assign rsp_start_time_out  = rsp_time_ff;
   assign rsp_result_ref_out  = rsp_rref_ff;
   assign rsp_in_flight_count = rsp_cnt_ff;

endmodule

// ===== rtl/round_robin_dispatch_reorder_unit.sv =====
// Round-robin dispatcher with an in-order reorder store.
// Commands come in on req_*: a transaction is taken on a clock edge with start
// high and busy low. req_cmd selects enqueue, worker completion, pop or restart.
// Enqueue tags the frame with a wrapping sequence number and names the worker;
// completions land in a slot picked by tag; pop releases results in tag order.
// Every command gives exactly one response on rsp_*, marked by rsp_valid for a
// single cycle. The receiver cannot stall; a response must be taken when shown.
// The accepting edge loads the command registers and enters EXEC; there the
// command runs against the tag counters and a single store port, and the
// response registers load as EXEC ends. A new command is taken only once busy
// has fallen after the previous one.
// The store read is registered and tracks the expected tag between commands.
// Registers on csr_*: index 0 worker_count, index 1 max_in_flight; write only
// while idle. Reset (synchronous, active high) clears all counters, slot flags
// and the response strobe, and loads worker_count 1 and max_in_flight 2.
// Restart clears the counters and slot flags but keeps the registers.
// STORE_DEPTH must be a power of two.
`include "round_robin_dispatch_reorder_unit_defines.svh"

module round_robin_dispatch_reorder_unit #(
   parameter int STORE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic [rrdr_pkg::HANDLE_BITS-1:0]     req_frame_ref,
   input  logic [rrdr_pkg::TIME_BITS-1:0]       req_start_time,
   input  logic [rrdr_pkg::TAG_BITS-1:0]        req_done_seq,
   input  logic [rrdr_pkg::HANDLE_BITS-1:0]     req_result_ref,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_status,
   output logic [rrdr_pkg::WIDX_BITS-1:0]       rsp_worker_index,
   output logic [rrdr_pkg::TAG_BITS-1:0]        rsp_seq_out,
   output logic [rrdr_pkg::HANDLE_BITS-1:0]     rsp_frame_ref_out,
   output logic [rrdr_pkg::TIME_BITS-1:0]       rsp_start_time_out,
   output logic [rrdr_pkg::HANDLE_BITS-1:0]     rsp_result_ref_out,
   output logic [rrdr_pkg::CNT_OUT_BITS-1:0]    rsp_in_flight_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrdr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rrdr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rrdr_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   rrdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   rrdr_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_cmd             (req_cmd),
      .req_frame_ref       (req_frame_ref),
      .req_start_time      (req_start_time),
      .req_done_seq        (req_done_seq),
      .req_result_ref      (req_result_ref),
      .rsp_status          (rsp_status),
      .rsp_worker_index    (rsp_worker_index),
      .rsp_seq_out         (rsp_seq_out),
      .rsp_frame_ref_out   (rsp_frame_ref_out),
      .rsp_start_time_out  (rsp_start_time_out),
      .rsp_result_ref_out  (rsp_result_ref_out),
      .rsp_in_flight_count (rsp_in_flight_count)
   );

   assign csr_ready = ~busy;

   // each accepted transaction yields its response after EXEC and the response register
   `RRDR_ASSERT_DELAY2(a_rsp_follows_req, clock, reset, start && !busy, rsp_valid)
   // busy falls in the cycle after it rises, with rsp_valid
   `RRDR_ASSERT_NEXT(a_busy_one_cycle, clock, reset, busy, !busy && rsp_valid)
   // refused pop never leaks a stored result
   `RRDR_ASSERT_IMPLIES(a_empty_pop_clean, clock, reset,
      rsp_valid && (rsp_status == ST_NOT_READY), rsp_result_ref_out == '0)

endmodule
